[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the task slice scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  // table depth default and field widths
  localparam int unsigned MaxTasksDef = 64;
  localparam int unsigned TimeW       = 24;
  localparam int unsigned ClockW      = 32;
  localparam int unsigned IdxOutW     = 6;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [TimeW-1:0] QuantumReset = TimeW'(500);

  // input opcodes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_NEXT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_IDLE  = 3'd0,
    KIND_RUN   = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_ADDED = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  // scheduling policies
  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPolicy  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgQuantum = CfgIdxW'(1);

endpackage

[sv/task_slice_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// task_slice_scheduler_unit
// Single-CPU scheduler: task table and ready ring held in memories,
// FIFO / round robin / SJF / preemptive SJF grant generation.
// ----------------------------------------------------------------------------
// channel   direction  beat contents
// s_axis    in         tuser: operation; tdata: arrival_time, run_length
// m_axis    out        tuser: grant_kind; tdata: task_index, start_time,
//                      chunk_length, task_finished
// cfg       in         index, data (policy_mode, round_quantum)
//
// SJF policies replace the ring pop by a scan of the ready ring.
// rst_ni clears control state; table contents are not cleared.
// a result waits in the output register; a full register stalls the last cycle.
module task_slice_scheduler_unit
  import tss_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [23:0] arrival_time, [47:24] run_length
  input  logic [47:0]         s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [5:0] task_index, [37:6] start_time, [61:38] chunk_length,
  // [62] task_finished, [63] zero
  output logic [63:0]         m_axis_tdata_o,
  // [2:0] grant_kind
  output logic [2:0]          m_axis_tuser_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TASKS);
  localparam logic [IW-1:0] LastPtr = IW'(MAX_TASKS - 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_ADM_RD  = 12'b000000000010,
    S_ADM_CHK = 12'b000000000100,
    S_SEL     = 12'b000000001000,
    S_POP_RD  = 12'b000000010000,
    S_POP     = 12'b000000100000,
    S_SCAN    = 12'b000001000000,
    S_SWAP    = 12'b000010000000,
    S_CRD     = 12'b000100000000,
    S_CALC    = 12'b001000000000,
    S_POST    = 12'b010000000000,
    S_EMIT    = 12'b100000000000
  } state_e;

  typedef enum logic [1:0] {
    RET_SEL   = 2'd0,
    RET_GAP   = 2'd1,
    RET_CHUNK = 2'd2
  } ret_e;

  function automatic logic [IW-1:0] ptr_next(input logic [IW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  // memories
  logic [TimeW-1:0] arr_mem [MAX_TASKS];
  logic [TimeW-1:0] rem_mem [MAX_TASKS];
  logic [IW-1:0]    ring_mem [MAX_TASKS];

  logic [TimeW-1:0] arr_rd_q, rem_rd_q;
  logic [IW-1:0]    ring_rd_q;
  logic [IW-1:0]    arr_raddr, rem_raddr, ring_raddr;
  logic             arr_we, rem_we, ring_we;
  logic [IW-1:0]    arr_waddr, rem_waddr, ring_waddr;
  logic [TimeW-1:0] arr_wdata, rem_wdata;
  logic [IW-1:0]    ring_wdata;

  // control and state registers
  state_e            state_q, state_d;
  ret_e              ret_q, ret_d;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d, loaded_q, loaded_d, arrived_q, arrived_d;
  logic [ClockW-1:0] ct_q, ct_d;
  logic [IW-1:0]     active_q, active_d;
  logic              open_q, open_d;
  logic [TimeW-1:0]  ql_q, ql_d;
  logic [TimeW-1:0]  last_arr_q, last_arr_d;
  logic [TimeW-1:0]  nxt_arr_q, nxt_arr_d;
  logic              pre_q, pre_d, fin_q, fin_d;
  policy_e           policy_q;
  logic [TimeW-1:0]  quantum_q;

  // sjf scan pipeline
  logic [IW-1:0]     scan_p_q, scan_p_d;
  logic [CW-1:0]     scan_n_q, scan_n_d;
  logic              s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [IW-1:0]     s1_p_q, s1_p_d, s2_p_q, s2_p_d, s2_task_q, s2_task_d;
  logic              first_q, first_d;
  logic [IW-1:0]     best_p_q, best_p_d, best_task_q, best_task_d;
  logic [IW-1:0]     head_task_q, head_task_d;
  logic [TimeW-1:0]  best_rem_q, best_rem_d;

  // pending result and output register
  kind_e              res_kind_q, res_kind_d;
  logic [IdxOutW-1:0] res_idx_q, res_idx_d;
  logic [ClockW-1:0]  res_start_q, res_start_d;
  logic [TimeW-1:0]   res_len_q, res_len_d;
  logic               res_fin_q, res_fin_d;
  logic               out_v_q;
  logic [63:0]        out_data_q;
  kind_e              out_kind_q;
  logic               emit_go;

  // input beat fields
  op_e              in_op;
  logic [TimeW-1:0] in_arr, in_len;
  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_arr = s_axis_tdata_i[23:0];
  assign in_len = s_axis_tdata_i[47:24];

  // chunk arithmetic
  logic [TimeW-1:0]  budget, chunk;
  logic [ClockW-1:0] gap;
  logic              has_next, preempt;
  assign has_next = arrived_q < loaded_q;
  assign budget   = (policy_q == POL_RR && ql_q < rem_rd_q) ? ql_q : rem_rd_q;
  assign gap      = {8'd0, nxt_arr_q} - ct_q;
  assign preempt  = has_next && (gap < {8'd0, budget});
  assign chunk    = preempt ? gap[TimeW-1:0] : budget;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign emit_go         = (state_q == S_EMIT) && (!out_v_q || m_axis_tready_i);

  // memory read addresses
  assign arr_raddr  = arrived_q[IW-1:0];
  assign ring_raddr = (state_q == S_SCAN) ? scan_p_q : head_q;
  assign rem_raddr  = (state_q == S_SCAN) ? ring_rd_q : active_q;

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (arr_we) arr_mem[arr_waddr] <= arr_wdata;
    if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    arr_rd_q  <= arr_mem[arr_raddr];
    rem_rd_q  <= rem_mem[rem_raddr];
    ring_rd_q <= ring_mem[ring_raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    head_d = head_q;  tail_d = tail_q;  count_d = count_q;
    loaded_d = loaded_q;  arrived_d = arrived_q;  ct_d = ct_q;
    active_d = active_q;  open_d = open_q;  ql_d = ql_q;
    last_arr_d = last_arr_q;  nxt_arr_d = nxt_arr_q;
    pre_d = pre_q;  fin_d = fin_q;
    scan_p_d = scan_p_q;  scan_n_d = scan_n_q;
    s1_v_d = 1'b0;  s1_p_d = s1_p_q;
    s2_v_d = 1'b0;  s2_p_d = s2_p_q;  s2_task_d = s2_task_q;
    first_d = first_q;  best_p_d = best_p_q;  best_task_d = best_task_q;
    head_task_d = head_task_q;  best_rem_d = best_rem_q;
    res_kind_d = res_kind_q;  res_idx_d = res_idx_q;  res_start_d = res_start_q;
    res_len_d = res_len_q;  res_fin_d = res_fin_q;
    arr_we = 1'b0;  arr_waddr = loaded_q[IW-1:0];  arr_wdata = in_arr;
    rem_we = 1'b0;  rem_waddr = loaded_q[IW-1:0];  rem_wdata = in_len;
    ring_we = 1'b0; ring_waddr = tail_q;  ring_wdata = arrived_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (in_op)
            OP_ADD: begin
              res_start_d = '0;  res_len_d = '0;  res_fin_d = 1'b0;
              if (loaded_q == MaxCnt || (loaded_q != '0 && in_arr < last_arr_q)) begin
                res_kind_d = KIND_ERROR;
                res_idx_d  = '0;
              end else begin
                res_kind_d = KIND_ADDED;
                res_idx_d  = IdxOutW'(loaded_q);
                arr_we     = 1'b1;
                rem_we     = 1'b1;
                last_arr_d = in_arr;
                loaded_d   = loaded_q + 1'b1;
              end
              state_d = S_EMIT;
            end
            OP_NEXT: begin
              ret_d   = RET_SEL;
              state_d = S_ADM_RD;
            end
            OP_CLEAR: begin
              head_d = '0;  tail_d = '0;  count_d = '0;
              loaded_d = '0;  arrived_d = '0;  ct_d = '0;
              active_d = '0;  open_d = 1'b0;  ql_d = '0;
            end
            default: ;
          endcase
        end
      end
      // admit arrivals whose ready time has come, one at a time
      S_ADM_RD: begin
        if (has_next) begin
          state_d = S_ADM_CHK;
        end else begin
          case (ret_q)
            RET_SEL:   state_d = S_SEL;
            RET_CHUNK: state_d = S_POST;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      S_ADM_CHK: begin
        nxt_arr_d = arr_rd_q;
        if ({8'd0, arr_rd_q} <= ct_q) begin
          if (count_q < MaxCnt) begin
            ring_we = 1'b1;
            tail_d  = ptr_next(tail_q);
            count_d = count_q + 1'b1;
          end
          arrived_d = arrived_q + 1'b1;
          state_d   = S_ADM_RD;
        end else begin
          case (ret_q)
            RET_SEL:   state_d = S_SEL;
            RET_CHUNK: state_d = S_POST;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      // pick what to do with the cpu
      S_SEL: begin
        if (open_q) begin
          state_d = S_CRD;
        end else if (count_q == '0) begin
          res_idx_d = '0;  res_fin_d = 1'b0;  res_start_d = ct_q;
          if (has_next) begin
            res_kind_d = KIND_IDLE;
            res_len_d  = gap[TimeW-1:0];
            ct_d       = {8'd0, nxt_arr_q};
            ret_d      = RET_GAP;
            state_d    = S_ADM_RD;
          end else begin
            res_kind_d = KIND_DONE;
            res_len_d  = '0;
            state_d    = S_EMIT;
          end
        end else begin
          open_d = 1'b1;
          ql_d   = (quantum_q == '0) ? TimeW'(1) : quantum_q;
          if (policy_q == POL_SJF || policy_q == POL_PSJF) begin
            scan_p_d = head_q;
            scan_n_d = '0;
            first_d  = 1'b1;
            state_d  = S_SCAN;
          end else begin
            state_d = S_POP_RD;
          end
        end
      end
      S_POP_RD: state_d = S_POP;
      S_POP: begin
        active_d = ring_rd_q;
        head_d   = ptr_next(head_q);
        count_d  = count_q - 1'b1;
        state_d  = S_CRD;
      end
      // ring entry read, then its remaining time, then compare
      S_SCAN: begin
        if (scan_n_q < count_q) begin
          s1_v_d   = 1'b1;
          s1_p_d   = scan_p_q;
          scan_p_d = ptr_next(scan_p_q);
          scan_n_d = scan_n_q + 1'b1;
        end
        s2_v_d    = s1_v_q;
        s2_p_d    = s1_p_q;
        s2_task_d = ring_rd_q;
        if (s2_v_q && (first_q || rem_rd_q < best_rem_q)) begin
          best_p_d    = s2_p_q;
          best_task_d = s2_task_q;
          best_rem_d  = rem_rd_q;
          first_d     = 1'b0;
          if (first_q) head_task_d = s2_task_q;
        end
        if (scan_n_q == count_q && !s1_v_q && !s2_v_q) state_d = S_SWAP;
      end
      S_SWAP: begin
        ring_we    = 1'b1;
        ring_waddr = best_p_q;
        ring_wdata = head_task_q;
        active_d   = best_task_q;
        head_d     = ptr_next(head_q);
        count_d    = count_q - 1'b1;
        state_d    = S_CRD;
      end
      S_CRD: state_d = S_CALC;
      // run one chunk of the active task
      S_CALC: begin
        rem_we      = 1'b1;
        rem_waddr   = active_q;
        rem_wdata   = rem_rd_q - chunk;
        fin_d       = (rem_rd_q == chunk);
        pre_d       = preempt;
        ql_d        = (ql_q >= chunk) ? ql_q - chunk : '0;
        ct_d        = ct_q + {8'd0, chunk};
        res_kind_d  = KIND_RUN;
        res_idx_d   = IdxOutW'(active_q);
        res_start_d = ct_q;
        res_len_d   = chunk;
        res_fin_d   = (rem_rd_q == chunk);
        ret_d       = RET_CHUNK;
        state_d     = S_ADM_RD;
      end
      // close the turn unless a non-PSJF preemption keeps it open; requeue where the policy says so
      S_POST: begin
        ring_wdata = active_q;
        if (!pre_q) begin
          open_d = 1'b0;
          if (policy_q == POL_RR && !fin_q && count_q < MaxCnt) begin
            ring_we = 1'b1;
            tail_d  = ptr_next(tail_q);
            count_d = count_q + 1'b1;
          end
        end else if (policy_q == POL_PSJF) begin
          open_d = 1'b0;
          if (count_q < MaxCnt) begin
            ring_we = 1'b1;
            tail_d  = ptr_next(tail_q);
            count_d = count_q + 1'b1;
          end
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= RET_SEL;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      loaded_q  <= '0;
      arrived_q <= '0;
      ct_q      <= '0;
      active_q  <= '0;
      open_q    <= 1'b0;
      ql_q      <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      policy_q  <= POL_FIFO;
      quantum_q <= QuantumReset;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      loaded_q  <= loaded_d;
      arrived_q <= arrived_d;
      ct_q      <= ct_d;
      active_q  <= active_d;
      open_q    <= open_d;
      ql_q      <= ql_d;
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      if (emit_go) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgPolicy) policy_q <= policy_e'(cfg_data_i[1:0]);
        if (cfg_index_i == CfgQuantum) quantum_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    last_arr_q  <= last_arr_d;
    nxt_arr_q   <= nxt_arr_d;
    pre_q       <= pre_d;
    fin_q       <= fin_d;
    scan_p_q    <= scan_p_d;
    scan_n_q    <= scan_n_d;
    s1_p_q      <= s1_p_d;
    s2_p_q      <= s2_p_d;
    s2_task_q   <= s2_task_d;
    first_q     <= first_d;
    best_p_q    <= best_p_d;
    best_task_q <= best_task_d;
    head_task_q <= head_task_d;
    best_rem_q  <= best_rem_d;
    res_kind_q  <= res_kind_d;
    res_idx_q   <= res_idx_d;
    res_start_q <= res_start_d;
    res_len_q   <= res_len_d;
    res_fin_q   <= res_fin_d;
    if (emit_go) begin
      out_kind_q <= res_kind_q;
      out_data_q <= {1'b0, res_fin_q, res_len_q, res_start_q, res_idx_q};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

`ifndef NO_ASSERTIONS
  // ring occupancy never exceeds the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("ready ring overflow");

  // arrivals never run ahead of loaded tasks
  a_arrived_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrived_q <= loaded_q) else $error("arrival pointer past loaded tasks");

  // a new result is only loaded when the output slot frees up
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !emit_go)
    else $error("result overwritten");
`endif

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the task slice scheduler. A directed table covers the
// edge cases: empty schedule, zero-length tasks, maximum ready and run times,
// out-of-order and late adds, no-op and clear. Random phases then follow. Each
// phase sets a policy and quantum, loads a task list and runs it to the end.
// Each grant is checked against its table row or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;
  import tss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth     = 64;
  localparam int unsigned SettleCyc = 300;
  localparam int unsigned WdogLimit = 20000;
  localparam int unsigned HoldCyc   = 400;
  localparam int unsigned ItemGoal  = 1600;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  idx;
    logic [31:0] start;
    logic [23:0] len;
    logic        fin;
  } grant_t;

  typedef struct {
    op_e         op;
    logic [23:0] arr;
    logic [23:0] len;
    bit          known;
    grant_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = OP_NOP;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgPolicy;
  logic [TimeW-1:0]   cfg_data = '0;
  logic        s_ready, m_valid, cfg_ready;
  logic [63:0] m_data;
  logic [2:0]  m_user;

  task_slice_scheduler_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [23:0] arr_tbl [Depth];
  logic [23:0] rem_tbl [Depth];
  logic [5:0]  ready_q [Depth];
  logic [5:0]  rq_head, rq_tail, active;
  logic [6:0]  rq_cnt, n_loaded, n_arrived;
  logic [31:0] now;
  logic        turn_open;
  logic [23:0] q_left;
  policy_e     pol = POL_FIFO;
  logic [23:0] quantum = QuantumReset;

  grant_t grants_due [$];
  int     fail_cnt = 0;
  bit     quiet = 1'b0;
  int     hold_asks = 0;
  int     items_sent = 0;

  function automatic void sched_clear();
    rq_head = '0; rq_tail = '0; rq_cnt = '0;
    n_loaded = '0; n_arrived = '0; now = '0;
    active = '0; turn_open = 1'b0; q_left = '0;
  endfunction

  function automatic void rq_push(logic [5:0] v);
    if (rq_cnt < Depth) begin
      ready_q[rq_tail] = v;
      rq_tail++;
      rq_cnt++;
    end
  endfunction

  function automatic logic [5:0] rq_pop();
    logic [5:0] v;
    v = ready_q[rq_head];
    rq_head++;
    rq_cnt--;
    return v;
  endfunction

  // earliest of the shortest entries swaps with the head, then pops
  function automatic logic [5:0] rq_pop_shortest();
    logic [5:0] best, p, t;
    best = rq_head;
    p = rq_head;
    for (int n = 0; n < rq_cnt; n++) begin
      if (rem_tbl[ready_q[p]] < rem_tbl[ready_q[best]]) best = p;
      p++;
    end
    t = ready_q[best];
    ready_q[best] = ready_q[rq_head];
    ready_q[rq_head] = t;
    return rq_pop();
  endfunction

  function automatic void admit_ready();
    while (n_arrived < n_loaded && arr_tbl[n_arrived[5:0]] <= now) begin
      rq_push(n_arrived[5:0]);
      n_arrived++;
    end
  endfunction

  // one input beat; returns 1 when a grant results
  function automatic bit sched_step(op_e op, logic [23:0] arr, logic [23:0] len,
                                    output grant_t g);
    logic [23:0] budget;
    logic [31:0] chunk, gap, start;
    bit          pre;
    g = '{KIND_IDLE, 6'd0, 32'd0, 24'd0, 1'b0};
    case (op)
      OP_ADD: begin
        if (n_loaded >= Depth ||
            (n_loaded > 0 && arr < arr_tbl[n_loaded[5:0] - 6'd1])) begin
          g.kind = KIND_ERROR;
          return 1'b1;
        end
        arr_tbl[n_loaded[5:0]] = arr;
        rem_tbl[n_loaded[5:0]] = len;
        g.kind = KIND_ADDED;
        g.idx = n_loaded[5:0];
        n_loaded++;
        return 1'b1;
      end
      OP_CLEAR: begin
        sched_clear();
        return 1'b0;
      end
      OP_NEXT: ;
      default: return 1'b0;
    endcase
    admit_ready();
    if (!turn_open) begin
      if (rq_cnt == 0) begin
        if (n_arrived < n_loaded) begin
          g.kind = KIND_IDLE;
          g.start = now;
          g.len = 24'(arr_tbl[n_arrived[5:0]] - now);
          now = 32'(arr_tbl[n_arrived[5:0]]);
          admit_ready();
        end else begin
          g.kind = KIND_DONE;
          g.start = now;
        end
        return 1'b1;
      end
      active = (pol == POL_SJF || pol == POL_PSJF) ? rq_pop_shortest() : rq_pop();
      turn_open = 1'b1;
      q_left = (quantum == 0) ? 24'd1 : quantum;
    end
    budget = rem_tbl[active];
    if (pol == POL_RR && q_left < budget) budget = q_left;
    pre = 1'b0;
    chunk = 32'(budget);
    if (n_arrived < n_loaded) begin
      gap = 32'(arr_tbl[n_arrived[5:0]]) - now;
      if (gap < 32'(budget)) begin
        chunk = gap;
        pre = 1'b1;
      end
    end
    start = now;
    rem_tbl[active] = rem_tbl[active] - chunk[23:0];
    q_left = (32'(q_left) >= chunk) ? q_left - chunk[23:0] : 24'd0;
    now = now + chunk;
    admit_ready();
    if (!pre) begin
      turn_open = 1'b0;
      if (pol == POL_RR && rem_tbl[active] > 0) rq_push(active);
    end else if (pol == POL_PSJF) begin
      turn_open = 1'b0;
      rq_push(active);
    end
    g = '{KIND_RUN, active, start, chunk[23:0], rem_tbl[active] == 0};
    return 1'b1;
  endfunction

  // send one beat; the expected grant (if any) is queued on acceptance
  task automatic send_beat(op_e op, logic [23:0] arr, logic [23:0] len,
                           bit known, grant_t want, output bit got, output grant_t g);
    if (!quiet && $urandom_range(99) < 14) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {len, arr};
    do @(posedge clk_i); while (!s_ready);
    got = sched_step(op, arr, len, g);
    if (got) grants_due.push_back(known ? want : g);
    items_sent++;
  endtask

  // wait for every grant, then let a trailing clear or no-op finish
  task automatic drain();
    s_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgPolicy) pol = policy_e'(val[1:0]);
    else quantum = val;
  endtask

  // receiver with random stalls and requested long hold-offs
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else if (holds_done != hold_asks) begin
      holds_done <= holds_done + 1;
      hold_left <= HoldCyc;
      m_ready <= 1'b0;
    end else begin
      m_ready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  // grant checker
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && m_valid && m_ready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected grant kind %0d", m_user);
        fail_cnt++;
      end else begin
        exp_g = grants_due.pop_front();
        if (m_user != exp_g.kind) begin
          $error("grant_kind exp %0d got %0d", exp_g.kind, m_user); fail_cnt++;
        end
        if (m_data[5:0] != exp_g.idx) begin
          $error("task_index exp %0d got %0d", exp_g.idx, m_data[5:0]); fail_cnt++;
        end
        if (m_data[37:6] != exp_g.start) begin
          $error("start_time exp %0h got %0h", exp_g.start, m_data[37:6]); fail_cnt++;
        end
        if (m_data[61:38] != exp_g.len) begin
          $error("chunk_length exp %0h got %0h", exp_g.len, m_data[61:38]); fail_cnt++;
        end
        if (m_data[62] != exp_g.fin) begin
          $error("task_finished exp %0d got %0d", exp_g.fin, m_data[62]); fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic grant_t mk(kind_e k, logic [5:0] i, logic [31:0] s,
                                logic [23:0] l, logic f);
    return '{k, i, s, l, f};
  endfunction

  initial begin
    row_t        rows [$];
    grant_t      g, none;
    bit          got;
    logic [23:0] t_arr, t_len;
    int          n_tasks, n_next, phase;
    none = mk(KIND_IDLE, 0, 0, 0, 0);
    sched_clear();

    // directed: empty, zero length, extremes, bad order, late add, no-op, clear
    rows = '{
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_DONE, 0, 0, 0, 0)},
      '{OP_ADD,   24'd0, 24'd0, 1, mk(KIND_ADDED, 0, 0, 0, 0)},
      '{OP_ADD,   24'd10, 24'hFFFFFF, 1, mk(KIND_ADDED, 1, 0, 0, 0)},
      '{OP_ADD,   24'd5, 24'd1, 1, mk(KIND_ERROR, 0, 0, 0, 0)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_RUN, 0, 0, 0, 1)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_IDLE, 0, 0, 10, 0)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_RUN, 1, 10, 24'hFFFFFF, 1)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_DONE, 0, 32'h01000009, 0, 0)},
      '{OP_NOP,   24'hFFFFFF, 24'hFFFFFF, 0, none},
      '{OP_CLEAR, 24'd0, 24'd0, 0, none},
      '{OP_ADD,   24'hFFFFFF, 24'd3, 1, mk(KIND_ADDED, 0, 0, 0, 0)},
      '{OP_ADD,   24'hFFFFFF, 24'd0, 1, mk(KIND_ADDED, 1, 0, 0, 0)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_IDLE, 0, 0, 24'hFFFFFF, 0)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_RUN, 0, 32'hFFFFFF, 3, 1)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_RUN, 1, 32'h01000002, 0, 1)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_DONE, 0, 32'h01000002, 0, 0)},
      '{OP_ADD,   24'hFFFFFF, 24'd7, 1, mk(KIND_ADDED, 2, 0, 0, 0)},
      '{OP_NEXT,  24'd0, 24'd0, 1, mk(KIND_RUN, 2, 32'h01000002, 7, 1)},
      '{OP_CLEAR, 24'd0, 24'd0, 0, none}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) send_beat(rows[r].op, rows[r].arr, rows[r].len,
                                rows[r].known, rows[r].want, got, g);
    drain();

    // random phases: policy and quantum, a task list, then run it out
    phase = 0;
    while (items_sent < ItemGoal) begin
      drain();
      quiet = (phase % 9 == 4);
      cfg_write(CfgPolicy, 24'(phase < 4 ? phase : $urandom_range(3)));
      case ($urandom_range(5))
        0: cfg_write(CfgQuantum, 24'd0);
        1: cfg_write(CfgQuantum, 24'd1);
        2: cfg_write(CfgQuantum, 24'hFFFFFF);
        3: cfg_write(CfgQuantum, 24'($urandom));
        default: cfg_write(CfgQuantum, 24'($urandom_range(1, 40)));
      endcase
      send_beat(OP_CLEAR, 24'($urandom), 24'($urandom), 0, none, got, g);
      if (phase == 6) hold_asks++;
      n_tasks = ($urandom_range(9) == 0) ? Depth + 1 : $urandom_range(1, 8);
      t_arr = 24'($urandom_range(20));
      for (int k = 0; k < n_tasks; k++) begin
        if ($urandom_range(15) == 0) t_arr = 24'($urandom);
        else if (t_arr < 24'hFFFF00) t_arr = t_arr + 24'($urandom_range(30));
        t_len = ($urandom_range(15) == 0) ? 24'($urandom) : 24'($urandom_range(60));
        // occasional out-of-order add, no-op, or early grant request
        if (k > 0 && $urandom_range(19) == 0)
          send_beat(OP_ADD, t_arr - 24'd1 - 24'($urandom_range(3)), t_len, 0, none, got, g);
        if ($urandom_range(29) == 0)
          send_beat(OP_NOP, 24'($urandom), 24'($urandom), 0, none, got, g);
        if ($urandom_range(9) == 0)
          send_beat(OP_NEXT, 24'($urandom), 24'($urandom), 0, none, got, g);
        send_beat(OP_ADD, t_arr, t_len, 0, none, got, g);
      end
      n_next = 0;
      do begin
        send_beat(OP_NEXT, 24'($urandom), 24'($urandom), 0, none, got, g);
        n_next++;
      end while (g.kind != KIND_DONE && n_next < 80);
      phase++;
    end
    drain();

    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
sv/tss_pkg.sv
sv/task_slice_scheduler_unit.sv
dv/tb.sv
